/* src/spq_pkg.sv */
package spq_pkg;

	localparam int DEPTH_DEF = 16;

	localparam int KEY_W = 32;
	localparam int SUM_W = 32;
	localparam int TAG_W = 16;
	localparam int OCC_W = 5;

	localparam int IN_DATA_W  = 80;
	localparam int OUT_DATA_W = 96;

	localparam logic [1:0] MODE_PUSH = 2'd0;
	localparam logic [1:0] MODE_POP  = 2'd1;
	localparam logic [1:0] MODE_PEEK = 2'd2;

	typedef enum logic [1:0] {
		STAT_OK         = 2'd0,
		STAT_POP_EMPTY  = 2'd1,
		STAT_PUSH_FULL  = 2'd2
	} status_t;

	typedef enum logic {
		ST_IDLE,
		ST_HOLD
	} state_t;

	// controller -> datapath
	typedef struct packed {
		logic    push;
		logic    pop;
		logic    capture;
		status_t status;
	} spq_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic empty;
		logic full;
	} spq_flags_t;

endpackage

/* src/spq_ctrl.sv */
module spq_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               s_tvalid,
	input  logic [1:0]         mode,
	input  logic               m_tready,
	input  spq_pkg::spq_flags_t flags,
	output logic               s_tready,
	output logic               m_tvalid,
	output spq_pkg::spq_cmd_t  cmd
);

	spq_pkg::state_t state_q;
	spq_pkg::state_t state_nxt;
	logic            accept;

	assign accept = s_tvalid && s_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= spq_pkg::ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			spq_pkg::ST_IDLE: begin
				if (accept) state_nxt = spq_pkg::ST_HOLD;
			end
			spq_pkg::ST_HOLD: begin
				if (m_tready && !accept) state_nxt = spq_pkg::ST_IDLE;
			end
			default: state_nxt = spq_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		s_tready    = (state_q == spq_pkg::ST_IDLE) || m_tready;
		m_tvalid    = (state_q == spq_pkg::ST_HOLD);
		cmd.push    = 1'b0;
		cmd.pop     = 1'b0;
		cmd.capture = accept;
		cmd.status  = spq_pkg::STAT_OK;
		if (accept) begin
			priority if (mode == spq_pkg::MODE_PUSH) begin
				if (flags.full) cmd.status = spq_pkg::STAT_PUSH_FULL;
				else cmd.push = 1'b1;
			end else if (mode == spq_pkg::MODE_POP) begin
				if (flags.empty) cmd.status = spq_pkg::STAT_POP_EMPTY;
				else cmd.pop = 1'b1;
			end else begin
				cmd.status = spq_pkg::STAT_OK;
			end
		end
	end

endmodule

/* src/spq_datapath.sv */
module spq_datapath #(
	parameter int DEPTH = spq_pkg::DEPTH_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  spq_pkg::spq_cmd_t               cmd,
	input  logic [spq_pkg::KEY_W-1:0]       key_time,
	input  logic signed [spq_pkg::SUM_W-1:0] payload_sum,
	input  logic [spq_pkg::TAG_W-1:0]       entry_tag,
	output spq_pkg::spq_flags_t             flags,
	output logic [spq_pkg::KEY_W-1:0]       head_time,
	output logic signed [spq_pkg::SUM_W-1:0] head_sum,
	output logic [spq_pkg::TAG_W-1:0]       head_tag,
	output logic [spq_pkg::OCC_W-1:0]       occupancy,
	output spq_pkg::status_t                status
);

	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [spq_pkg::KEY_W-1:0]        tm_q  [DEPTH];
	logic signed [spq_pkg::SUM_W-1:0] sum_q [DEPTH];
	logic [spq_pkg::TAG_W-1:0]        tag_q [DEPTH];
	logic [CNT_W-1:0]                 count_q;
	spq_pkg::status_t                 status_q;

	// one compare-and-shift cell per slot
	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic at_or_below;
		logic prev_gt;
		logic take_new;

		assign at_or_below = CNT_W'(i) <= count_q;
		if (i == 0) begin : g_first
			assign prev_gt = 1'b0;
		end else begin : g_rest
			assign prev_gt = tm_q[i-1] > key_time;
		end
		assign take_new = (CNT_W'(i) == count_q) || (tm_q[i] > key_time);

		always_ff @(posedge clk) begin
			if (cmd.push && at_or_below) begin
				if (prev_gt) begin
					if (i > 0) begin
						tm_q[i]  <= tm_q[(i > 0) ? i-1 : 0];
						sum_q[i] <= sum_q[(i > 0) ? i-1 : 0];
						tag_q[i] <= tag_q[(i > 0) ? i-1 : 0];
					end
				end else if (take_new) begin
					tm_q[i]  <= key_time;
					sum_q[i] <= payload_sum;
					tag_q[i] <= entry_tag;
				end
			end else if (cmd.pop && (i < DEPTH - 1)) begin
				tm_q[i]  <= tm_q[(i < DEPTH - 1) ? i+1 : i];
				sum_q[i] <= sum_q[(i < DEPTH - 1) ? i+1 : i];
				tag_q[i] <= tag_q[(i < DEPTH - 1) ? i+1 : i];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q  <= '0;
			status_q <= spq_pkg::STAT_OK;
		end else begin
			if (cmd.push) count_q <= count_q + CNT_W'(1);
			else if (cmd.pop) count_q <= count_q - CNT_W'(1);
			if (cmd.capture) status_q <= cmd.status;
		end
	end

	assign flags.empty = (count_q == '0);
	assign flags.full  = (count_q == CNT_W'(DEPTH));
	assign head_time   = flags.empty ? '0 : tm_q[0];
	assign head_sum    = flags.empty ? '0 : sum_q[0];
	assign head_tag    = flags.empty ? '0 : tag_q[0];
	assign occupancy   = spq_pkg::OCC_W'(count_q);
	assign status      = status_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(DEPTH))
		else $error("entry count beyond depth");

	a_push_grows: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.push |=> count_q == $past(count_q) + CNT_W'(1))
		else $error("push did not add an entry");

	a_pop_shrinks: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.pop |=> count_q == $past(count_q) - CNT_W'(1))
		else $error("pop did not remove an entry");

	a_no_bad_op: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.push && !flags.full) || (cmd.pop && !flags.empty) || (!cmd.push && !cmd.pop))
		else $error("queue op issued against full or empty queue");

endmodule

/* src/sorted_priority_queue.sv */
// The result of an accepted item is on m_tdata in the cycle after acceptance.
// Throughput: one item per cycle while m_tready is high; every slot is a compare-and-shift
//   cell, so a push or pop updates all DEPTH slots together.
// A result waiting on m_tready holds s_tready low; with m_tready high, s_tready stays high.
// Reset (arst_n low, asynchronous): entry count zero, no result pending;
//   slot registers are not reset and are only read below the count.
module sorted_priority_queue #(
	parameter int DEPTH = spq_pkg::DEPTH_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	// input item
	input  logic                              s_tvalid,
	output logic                              s_tready,
	input  logic [spq_pkg::IN_DATA_W-1:0]     s_tdata,  // key_time[31:0], payload_sum[63:32], entry_tag[79:64]
	input  logic [1:0]                        s_tuser,  // mode[1:0]
	// result item
	output logic                              m_tvalid,
	input  logic                              m_tready,
	output logic [spq_pkg::OUT_DATA_W-1:0]    m_tdata   // head_time[31:0], head_sum[63:32],
	                                                    // head_tag[79:64], is_empty[80], is_full[81],
	                                                    // occupancy[86:82], status[88:87], zero[95:89]
);

	spq_pkg::spq_cmd_t   cmd;
	spq_pkg::spq_flags_t flags;

	logic [spq_pkg::KEY_W-1:0]        head_time;
	logic signed [spq_pkg::SUM_W-1:0] head_sum;
	logic [spq_pkg::TAG_W-1:0]        head_tag;
	logic [spq_pkg::OCC_W-1:0]        occupancy;
	spq_pkg::status_t                 status;

	// Handshake and op decode; a rejected push or pop only sets the status.
	spq_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.mode     (s_tuser),
		.m_tready (m_tready),
		.flags    (flags),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.cmd      (cmd)
	);

	// Sorted slot chain. Equal keys keep arrival order: a new entry lands behind
	// every entry whose key is not greater than its own.
	spq_datapath #(
		.DEPTH (DEPTH)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.key_time    (s_tdata[31:0]),
		.payload_sum (s_tdata[63:32]),
		.entry_tag   (s_tdata[79:64]),
		.flags       (flags),
		.head_time   (head_time),
		.head_sum    (head_sum),
		.head_tag    (head_tag),
		.occupancy   (occupancy),
		.status      (status)
	);

	// The queue state only moves when a new item is taken, which also replaces
	// the pending result, so the live head is the result of the last item.
	assign m_tdata = {7'd0, status, occupancy, flags.full, flags.empty,
		head_tag, head_sum, head_time};

endmodule

/* tb/tb_sorted_priority_queue.sv */
`timescale 1ns / 100ps

module tb_sorted_priority_queue;
	import spq_pkg::*;

	localparam int QDEPTH = DEPTH_DEF;
	localparam logic [1:0] MODE_SPARE = 2'd3;  // unused code, acts as a peek
	localparam int RANDOM_ITEMS = 1300;
	localparam int STALL_LIMIT = 2000;          // cycles with no item moving on either side
	localparam int PRESSURE_CYCLES = 150;
	localparam int PRESSURE_AFTER = 500;        // results seen before the long hold-off
	localparam int DRAIN_CYCLES = 8;

	typedef struct {
		logic [KEY_W-1:0] key;
		logic [SUM_W-1:0] amount;
		logic [TAG_W-1:0] tag;
	} slot_t;

	typedef struct {
		logic [KEY_W-1:0] head_time;
		logic [SUM_W-1:0] head_sum;
		logic [TAG_W-1:0] head_tag;
		logic             is_empty;
		logic             is_full;
		logic [OCC_W-1:0] occupancy;
		status_t          status;
	} head_report_t;

	class head_scoreboard;
		slot_t        mirror[$];          // sorted copy of the queue, head at index 0
		head_report_t expected_heads[$];
		int errors = 0;
		int results_seen = 0;
		int n_push = 0, n_drop = 0, n_pop = 0, n_pop_empty = 0, n_peek = 0, max_fill = 0;

		// apply one accepted item to the mirror and queue up the report it must produce
		function void note_item(logic [1:0] op, logic [KEY_W-1:0] key,
				logic [SUM_W-1:0] amount, logic [TAG_W-1:0] tag);
			head_report_t r;
			slot_t s;
			int pos;
			r.status = STAT_OK;
			case (op)
				MODE_PUSH: begin
					n_push++;
					if (mirror.size() >= QDEPTH) begin
						r.status = STAT_PUSH_FULL;
						n_drop++;
					end else begin
						s.key = key;
						s.amount = amount;
						s.tag = tag;
						// land behind every entry with key <= new key: ties keep arrival order
						pos = mirror.size();
						while (pos > 0 && mirror[pos-1].key > key)
							pos--;
						mirror.insert(pos, s);
					end
				end
				MODE_POP: begin
					n_pop++;
					if (mirror.size() == 0) begin
						r.status = STAT_POP_EMPTY;
						n_pop_empty++;
					end else begin
						void'(mirror.pop_front());
					end
				end
				default: n_peek++;
			endcase
			if (mirror.size() > max_fill)
				max_fill = mirror.size();
			if (mirror.size() > 0) begin
				r.head_time = mirror[0].key;
				r.head_sum  = mirror[0].amount;
				r.head_tag  = mirror[0].tag;
			end else begin
				r.head_time = '0;
				r.head_sum  = '0;
				r.head_tag  = '0;
			end
			r.is_empty  = (mirror.size() == 0);
			r.is_full   = (mirror.size() == QDEPTH);
			r.occupancy = OCC_W'(mirror.size());
			expected_heads.push_back(r);
		endfunction

		function void cmp_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
			if (act_v !== exp_v) begin
				$error("%s mismatch: expected %h actual %h", name, exp_v, act_v);
				errors++;
			end
		endfunction

		function void check_head(logic [OUT_DATA_W-1:0] word);
			head_report_t e;
			results_seen++;
			if (expected_heads.size() == 0) begin
				$error("result with no item outstanding: %h", word);
				errors++;
				return;
			end
			e = expected_heads.pop_front();
			cmp_field("head_time", e.head_time, word[31:0]);
			cmp_field("head_sum",  e.head_sum,  word[63:32]);
			cmp_field("head_tag",  32'(e.head_tag),  32'(word[79:64]));
			cmp_field("is_empty",  32'(e.is_empty),  32'(word[80]));
			cmp_field("is_full",   32'(e.is_full),   32'(word[81]));
			cmp_field("occupancy", 32'(e.occupancy), 32'(word[86:82]));
			cmp_field("status",    32'(e.status),    32'(word[88:87]));
		endfunction

		function int outstanding();
			return expected_heads.size();
		endfunction
	endclass

	logic                  clk;
	logic                  arst_n;
	logic                  s_tvalid;
	logic                  s_tready;
	logic [IN_DATA_W-1:0]  s_tdata;   // key_time[31:0], payload_sum[63:32], entry_tag[79:64]
	logic [1:0]            s_tuser;   // mode[1:0]
	logic                  m_tvalid;
	logic                  m_tready;
	logic [OUT_DATA_W-1:0] m_tdata;   // head_time, head_sum, head_tag, is_empty, is_full,
	                                  // occupancy, status, zero pad

	head_scoreboard sb;
	int  idle_cycles;
	bit  pressure_done;

	sorted_priority_queue #(.DEPTH(QDEPTH)) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	always #6 clk = ~clk;

	// mostly no gap, some short, a few long
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 50)
			return 0;
		else if (r < 85)
			return $urandom_range(1, 3);
		else if (r < 97)
			return $urandom_range(4, 10);
		else
			return $urandom_range(20, 40);
	endfunction

	// offer one item from the falling edge, hold it until a rising edge accepts it
	task automatic send_op(input logic [1:0] op, input logic [KEY_W-1:0] key,
			input logic [SUM_W-1:0] amount, input logic [TAG_W-1:0] tag);
		@(negedge clk);
		s_tvalid <= 1'b1;
		s_tuser  <= op;
		s_tdata  <= {tag, amount, key};
		do @(posedge clk); while (!s_tready);
	endtask

	task automatic idle_sender(input int n);
		if (n > 0) begin
			@(negedge clk);
			s_tvalid <= 1'b0;
			repeat (n - 1) @(negedge clk);
		end
	endtask

	// both handshakes sampled at the rising edge, before any register updates
	always @(posedge clk) begin
		if (arst_n) begin
			if (s_tvalid && s_tready)
				sb.note_item(s_tuser, s_tdata[31:0], s_tdata[63:32], s_tdata[79:64]);
			if (m_tvalid && m_tready)
				sb.check_head(m_tdata);
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
				idle_cycles <= 0;
			end else begin
				idle_cycles <= idle_cycles + 1;
				if (idle_cycles >= STALL_LIMIT) begin
					$display("TB_ERROR");
					$finish;
				end
			end
		end
	end

	// receiver: ready runs broken by random gaps, plus one long hold-off so the queue backs up
	initial begin
		int run_len;
		int gap;
		m_tready = 1'b0;
		wait (arst_n === 1'b1);
		@(negedge clk);
		forever begin
			if (!pressure_done && sb.results_seen >= PRESSURE_AFTER) begin
				m_tready <= 1'b0;
				repeat (PRESSURE_CYCLES) @(negedge clk);
				pressure_done = 1'b1;
			end
			run_len = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 150)
				: $urandom_range(1, 12);
			gap = pick_gap();
			m_tready <= 1'b1;
			repeat (run_len) @(negedge clk);
			if (gap > 0) begin
				m_tready <= 1'b0;
				repeat (gap) @(negedge clk);
			end
		end
	end

	initial begin
		int sent;
		int burst_len;
		int push_pct;
		int r;
		logic [1:0] op;
		logic [KEY_W-1:0] key;

		sb = new;
		clk = 1'b0;
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = MODE_PEEK;
		idle_cycles = 0;
		pressure_done = 1'b0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// empty queue: pop error, peek, spare mode with junk fields
		send_op(MODE_POP, 32'hFFFF_FFFF, 32'h8000_0000, 16'hFFFF);
		send_op(MODE_PEEK, 32'h1234_5678, 32'h7FFF_FFFF, 16'hA5A5);
		send_op(MODE_SPARE, $urandom(), $urandom(), 16'($urandom()));
		// push onto empty, then extremes of key, payload and tag
		send_op(MODE_PUSH, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 16'h0000);
		send_op(MODE_PUSH, 32'h0000_0000, 32'h8000_0000, 16'hFFFF);
		// equal keys must leave in arrival order
		send_op(MODE_PUSH, 32'h0005_0000, 32'hFFFF_FFFF, 16'h000A);
		send_op(MODE_PUSH, 32'h0005_0000, 32'h0000_0001, 16'h000B);
		idle_sender(3);
		send_op(MODE_PUSH, 32'h0005_0000, 32'h0000_0000, 16'h000C);
		send_op(MODE_PEEK, '0, '0, '0);
		send_op(MODE_SPARE, '1, '1, '1);
		repeat (6) send_op(MODE_POP, $urandom(), $urandom(), 16'($urandom()));
		send_op(MODE_POP, '0, '0, '0);

		// bursts lean toward push, mixed or pop so the fill swings between empty and full
		sent = 0;
		while (sent < RANDOM_ITEMS) begin
			burst_len = $urandom_range(8, 60);
			case ($urandom_range(0, 2))
				0: push_pct = 85;
				1: push_pct = 50;
				default: push_pct = 15;
			endcase
			repeat (burst_len) begin
				r = $urandom_range(0, 99);
				if (r < push_pct) begin
					op = MODE_PUSH;
				end else begin
					r = $urandom_range(0, 19);
					op = (r < 15) ? MODE_POP : (r < 19) ? MODE_PEEK : MODE_SPARE;
				end
				// narrow keys give plenty of ties; some extremes; rest full range
				r = $urandom_range(0, 99);
				if (r < 45) begin
					key = $urandom_range(0, 15);
				end else if (r < 55) begin
					case ($urandom_range(0, 3))
						0: key = '0;
						1: key = '1;
						2: key = 32'h7FFF_FFFF;
						default: key = 32'h8000_0000;
					endcase
				end else begin
					key = $urandom();
				end
				send_op(op, key, $urandom(), 16'($urandom()));
				idle_sender(pick_gap());
				sent++;
			end
		end

		@(negedge clk);
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (sb.outstanding() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Run: %0d pushes (%0d dropped on full), %0d pops (%0d on empty), %0d peeks.",
			sb.n_push, sb.n_drop, sb.n_pop, sb.n_pop_empty, sb.n_peek);
		$display("Deepest fill %0d of %0d; long receiver hold-off %s; %0d results checked.",
			sb.max_fill, QDEPTH, pressure_done ? "done" : "not reached", sb.results_seen);
		if (sb.errors == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
